### hdl/btc_pkg.sv
`timescale 1ns / 1ps

package btc_pkg;

   localparam int TempStages = 5;
   localparam int PreStages  = 9;
   localparam int DivStages  = 64;
   localparam int PostStages = 7;

   localparam logic [63:0] FineOffset = 64'd128000;
   localparam logic [63:0] NumScale   = 64'd3125;
   localparam logic [20:0] RawFull    = 21'd1048576;
   localparam logic [63:0] OneQ47     = 64'h0000_8000_0000_0000;

   localparam logic [1:0] RegTempCoeffs     = 2'd0;
   localparam logic [1:0] RegPressCoeffsLow = 2'd1;
   localparam logic [1:0] RegPressCoeffsMid = 2'd2;
   localparam logic [1:0] RegPressCoeffsHigh = 2'd3;

   typedef struct packed {
      logic [47:0] temp;
      logic [47:0] plow;
      logic [47:0] pmid;
      logic [47:0] phigh;
   } coeff_type;

   typedef struct packed {
      logic [63:0] v1;
      logic [20:0] pp;
      logic [31:0] centi;
   } temp_out_type;

   typedef struct packed {
      logic [63:0] num;
      logic [30:0] dvs;
      logic        neg;
      logic        invalid;
      logic [31:0] centi;
   } pre_out_type;

   typedef struct packed {
      logic [30:0] rem;
      logic [63:0] qn;
      logic [30:0] dvs;
      logic        neg;
      logic        invalid;
      logic [31:0] centi;
   } div_stage_type;

   function automatic logic [63:0] sext16(logic [15:0] w);
      return {{48{w[15]}}, w};
   endfunction

endpackage

### hdl/btc_mul.sv
`timescale 1ns / 1ps

// Low 64 bits of a 64 by 64 product, from three 32 by 32 partial products.
module btc_mul (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] p
);

   logic [63:0] ll_in, ll_ff;
   logic [63:0] lh_in, hl_in;
   logic [31:0] cross_ff;
   logic [63:0] p_ff;

   assign ll_in = a[31:0] * b[31:0];
   assign lh_in = a[31:0] * b[63:32];
   assign hl_in = a[63:32] * b[31:0];

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff    <= ll_in;
         cross_ff <= lh_in[31:0] + hl_in[31:0];
         p_ff     <= ll_ff + {cross_ff, 32'd0};
      end
   end

   assign p = p_ff;

endmodule

### hdl/btc_temp.sv
`timescale 1ns / 1ps

module btc_temp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [19:0]           raw_temperature,
   input  logic [19:0]           raw_pressure,
   input  btc_pkg::coeff_type    coeffs,
   output logic                  out_valid,
   output btc_pkg::temp_out_type out_data
);

   localparam int TempStagesM1 = btc_pkg::TempStages - 1;

   logic [15:0] t1, t2, t3;
   logic [17:0] a_ff, b_ff;
   logic [31:0] m1_ff, bb_ff, x1_ff, m2_ff, fine_ff;
   logic signed [33:0] m1_c;
   logic signed [35:0] bb_c, m2_c;
   logic [31:0] x1_c, x2_c, t5_c;
   logic [20:0] pp_ff [TempStagesM1];
   logic [TempStagesM1-1:0] valid_ff;
   logic out_valid_ff;
   btc_pkg::temp_out_type out_ff;

   assign t1 = coeffs.temp[15:0];
   assign t2 = coeffs.temp[31:16];
   assign t3 = coeffs.temp[47:32];

   assign m1_c = $signed(a_ff) * $signed(t2);
   assign bb_c = $signed(b_ff) * $signed(b_ff);
   assign x1_c = {{11{m1_ff[31]}}, m1_ff[31:11]};
   // The square is taken to 32 bits and shifted down by twelve before the T3 product.
   assign m2_c = $signed(bb_ff[31:12]) * $signed(t3);
   assign x2_c = {{14{m2_ff[31]}}, m2_ff[31:14]};
   assign t5_c = {fine_ff[29:0], 2'd0} + fine_ff + 32'd128;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= {valid_ff[TempStagesM1-2:0], in_valid};
         out_valid_ff <= valid_ff[TempStagesM1-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff      <= {1'b0, raw_temperature[19:3]} - {1'b0, t1, 1'b0};
         b_ff      <= {2'd0, raw_temperature[19:4]} - {2'd0, t1};
         pp_ff[0]  <= btc_pkg::RawFull - {1'b0, raw_pressure};
         for (int k = 1; k < TempStagesM1; k++) begin
            pp_ff[k] <= pp_ff[k-1];
         end
         m1_ff     <= m1_c[31:0];
         bb_ff     <= bb_c[31:0];
         x1_ff     <= x1_c;
         m2_ff     <= m2_c[31:0];
         fine_ff   <= x1_ff + x2_c;
         out_ff.centi <= {{8{t5_c[31]}}, t5_c[31:8]};
         out_ff.v1    <= {{32{fine_ff[31]}}, fine_ff} - btc_pkg::FineOffset;
         out_ff.pp    <= pp_ff[TempStagesM1-1];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

### hdl/btc_press_pre.sv
`timescale 1ns / 1ps

module btc_press_pre (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  btc_pkg::temp_out_type in_data,
   input  btc_pkg::coeff_type    coeffs,
   output logic                  out_valid,
   output btc_pkg::pre_out_type  out_data
);

   localparam int SideLen = btc_pkg::PreStages - 1;
   localparam int PpLen   = 5;

   logic [63:0] p1, p2, p3, p4, p5, p6;
   logic [63:0] sq, v1p5, v1p2, sqp6, sqp3, num_m, prod_m;
   logic [63:0] v1p5_ff [2];
   logic [63:0] v1p2_ff [2];
   logic [63:0] v2_ff, v1b_ff, n0_ff, v1bd_ff;
   logic [63:0] sqp3_sh;
   logic [30:0] d_c;
   logic [20:0] pp_ff [PpLen];
   logic [31:0] centi_ff [SideLen];
   logic [SideLen-1:0] valid_ff;
   logic out_valid_ff;
   btc_pkg::pre_out_type out_ff;

   assign p1 = {48'd0, coeffs.plow[15:0]};
   assign p2 = btc_pkg::sext16(coeffs.plow[31:16]);
   assign p3 = btc_pkg::sext16(coeffs.plow[47:32]);
   assign p4 = btc_pkg::sext16(coeffs.pmid[15:0]);
   assign p5 = btc_pkg::sext16(coeffs.pmid[31:16]);
   assign p6 = btc_pkg::sext16(coeffs.pmid[47:32]);

   btc_mul u_mul_sq (.clock(clock), .en(en), .a(in_data.v1), .b(in_data.v1), .p(sq));
   btc_mul u_mul_p5 (.clock(clock), .en(en), .a(in_data.v1), .b(p5), .p(v1p5));
   btc_mul u_mul_p2 (.clock(clock), .en(en), .a(in_data.v1), .b(p2), .p(v1p2));
   btc_mul u_mul_p6 (.clock(clock), .en(en), .a(sq), .b(p6), .p(sqp6));
   btc_mul u_mul_p3 (.clock(clock), .en(en), .a(sq), .b(p3), .p(sqp3));
   btc_mul u_mul_num (.clock(clock), .en(en), .a(n0_ff), .b(btc_pkg::NumScale), .p(num_m));
   btc_mul u_mul_p1 (.clock(clock), .en(en), .a(v1bd_ff), .b(p1), .p(prod_m));

   assign sqp3_sh = {{8{sqp3[63]}}, sqp3[63:8]};
   // The divisor is the product shifted down by 33, which always fits in 31 bits.
   assign d_c = prod_m[63:33];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= {valid_ff[SideLen-2:0], in_valid};
         out_valid_ff <= valid_ff[SideLen-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff[0]    <= in_data.pp;
         centi_ff[0] <= in_data.centi;
         for (int k = 1; k < PpLen; k++) begin
            pp_ff[k] <= pp_ff[k-1];
         end
         for (int k = 1; k < SideLen; k++) begin
            centi_ff[k] <= centi_ff[k-1];
         end
         v1p5_ff[0] <= v1p5;
         v1p5_ff[1] <= v1p5_ff[0];
         v1p2_ff[0] <= v1p2;
         v1p2_ff[1] <= v1p2_ff[0];
         v2_ff   <= sqp6 + {v1p5_ff[1][46:0], 17'd0} + {p4[28:0], 35'd0};
         v1b_ff  <= sqp3_sh + {v1p2_ff[1][51:0], 12'd0} + btc_pkg::OneQ47;
         n0_ff   <= {12'd0, pp_ff[PpLen-1], 31'd0} - v2_ff;
         v1bd_ff <= v1b_ff;
         out_ff.num     <= num_m[63] ? (64'd0 - num_m) : num_m;
         out_ff.dvs     <= d_c[30] ? (31'd0 - d_c) : d_c;
         out_ff.neg     <= num_m[63] ^ d_c[30];
         out_ff.invalid <= (d_c == 31'd0);
         out_ff.centi   <= centi_ff[SideLen-1];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

### hdl/btc_div.sv
`timescale 1ns / 1ps

// Restoring unsigned division, one quotient bit per stage. The dividend shifts out
// of the top of qn while quotient bits shift in at the bottom.
module btc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  btc_pkg::pre_out_type in_data,
   output logic                 out_valid,
   output btc_pkg::div_stage_type out_data
);

   localparam int N = btc_pkg::DivStages;

   btc_pkg::div_stage_type src [N];
   btc_pkg::div_stage_type nxt [N];
   btc_pkg::div_stage_type st_ff [N];
   logic [N-1:0] valid_ff;

   always_comb begin
      src[0].rem     = '0;
      src[0].qn      = in_data.num;
      src[0].dvs     = in_data.dvs;
      src[0].neg     = in_data.neg;
      src[0].invalid = in_data.invalid;
      src[0].centi   = in_data.centi;
      for (int k = 1; k < N; k++) begin
         src[k] = st_ff[k-1];
      end
   end

   always_comb begin
      logic [31:0] trial;
      logic [31:0] diff;
      logic        ge;
      for (int k = 0; k < N; k++) begin
         trial = {src[k].rem, src[k].qn[63]};
         diff  = trial - {1'b0, src[k].dvs};
         ge    = (trial >= {1'b0, src[k].dvs});
         nxt[k]     = src[k];
         nxt[k].rem = ge ? diff[30:0] : trial[30:0];
         nxt[k].qn  = {src[k].qn[62:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            st_ff[k] <= nxt[k];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_data  = st_ff[N-1];

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      valid_ff[N-1] && !st_ff[N-1].invalid |-> st_ff[N-1].rem < st_ff[N-1].dvs)
      else $error("division remainder not below divisor");

   a_valid_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] && !st_ff[0].invalid |-> st_ff[0].dvs != 31'd0)
      else $error("zero divisor not flagged invalid");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> valid_ff == '0)
      else $error("division pipeline holds an item after reset");

endmodule

### hdl/btc_press_post.sv
`timescale 1ns / 1ps

module btc_press_post (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  btc_pkg::div_stage_type in_data,
   input  btc_pkg::coeff_type     coeffs,
   output logic                   out_valid,
   output logic [31:0]            temperature_centi,
   output logic [31:0]            pressure_q24_8,
   output logic                   pressure_invalid
);

   localparam int SideLen = btc_pkg::PostStages - 1;

   logic [63:0] p7, p8, p9;
   logic [63:0] p_ff, qq_c, sqq, p8p, w_m;
   logic [63:0] p_d [4];
   logic [63:0] p8p_d [2];
   logic [63:0] w1_sh, w2_sh, sum_ff;
   logic [31:0] centi_ff [SideLen];
   logic [SideLen-1:0] inv_ff;
   logic [SideLen-1:0] valid_ff;
   logic out_valid_ff;
   logic [31:0] centi_out_ff, press_out_ff;
   logic inv_out_ff;

   assign p7 = btc_pkg::sext16(coeffs.phigh[15:0]);
   assign p8 = btc_pkg::sext16(coeffs.phigh[31:16]);
   assign p9 = btc_pkg::sext16(coeffs.phigh[47:32]);

   assign qq_c = {{13{p_ff[63]}}, p_ff[63:13]};

   btc_mul u_mul_qq (.clock(clock), .en(en), .a(qq_c), .b(qq_c), .p(sqq));
   btc_mul u_mul_p8 (.clock(clock), .en(en), .a(p_ff), .b(p8), .p(p8p));
   btc_mul u_mul_p9 (.clock(clock), .en(en), .a(sqq), .b(p9), .p(w_m));

   assign w1_sh = {{25{w_m[63]}}, w_m[63:25]};
   assign w2_sh = {{19{p8p_d[1][63]}}, p8p_d[1][63:19]};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= {valid_ff[SideLen-2:0], in_valid};
         out_valid_ff <= valid_ff[SideLen-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff        <= in_data.neg ? (64'd0 - in_data.qn) : in_data.qn;
         centi_ff[0] <= in_data.centi;
         inv_ff[0]   <= in_data.invalid;
         for (int k = 1; k < SideLen; k++) begin
            centi_ff[k] <= centi_ff[k-1];
            inv_ff[k]   <= inv_ff[k-1];
         end
         p_d[0]   <= p_ff;
         for (int k = 1; k < 4; k++) begin
            p_d[k] <= p_d[k-1];
         end
         p8p_d[0] <= p8p;
         p8p_d[1] <= p8p_d[0];
         sum_ff   <= p_d[3] + w1_sh + w2_sh;
         centi_out_ff <= centi_ff[SideLen-1];
         inv_out_ff   <= inv_ff[SideLen-1];
         // With a zero divisor the pressure is forced to zero.
         press_out_ff <= inv_ff[SideLen-1] ? 32'd0 : (sum_ff[39:8] + {p7[27:0], 4'd0});
      end
   end

   assign out_valid         = out_valid_ff;
   assign temperature_centi = centi_out_ff;
   assign pressure_q24_8    = press_out_ff;
   assign pressure_invalid  = inv_out_ff;

endmodule

### hdl/baro_temp_compensation.sv
`timescale 1ns / 1ps

// Barometric temperature and pressure compensation.
// The request channel takes one raw temperature and raw pressure pair per beat,
// with valid and stall; the response channel returns the temperature in
// hundredths of a degree, the pressure in Pa as unsigned Q24.8 and a flag that
// marks a zero divisor, in which case the pressure reads zero.
// The csr channel writes the four 48-bit calibration registers; csr_ready is
// always high. Write them only while no beat is in flight.
// A beat is accepted every cycle while the response side does not stall. It passes
// 85 register stages: 5 temperature stages, 9 pressure stages with pipelined
// 64-bit multipliers, 64 divider stages at one quotient bit each and 7 final stages.
// When the response side stalls a waiting result, the whole pipeline holds and
// req_stall rises, so nothing is lost or repeated.
// Reset empties the pipeline and clears the calibration registers to zero.
module baro_temp_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [19:0] req_raw_temperature,
   input  logic [19:0] req_raw_pressure,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_temperature_centi,
   output logic [31:0] rsp_pressure_q24_8,
   output logic        rsp_pressure_invalid,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   btc_pkg::coeff_type coeffs_ff;
   logic en;
   logic temp_valid, pre_valid, div_valid;
   btc_pkg::temp_out_type temp_data;
   btc_pkg::pre_out_type pre_data;
   btc_pkg::div_stage_type div_data;
   logic [31:0] centi_w;

   assign csr_ready = 1'b1;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeffs_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            btc_pkg::RegTempCoeffs:      coeffs_ff.temp  <= csr_wdata;
            btc_pkg::RegPressCoeffsLow:  coeffs_ff.plow  <= csr_wdata;
            btc_pkg::RegPressCoeffsMid:  coeffs_ff.pmid  <= csr_wdata;
            btc_pkg::RegPressCoeffsHigh: coeffs_ff.phigh <= csr_wdata;
         endcase
      end
   end

   btc_temp u_temp (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_valid), .raw_temperature(req_raw_temperature),
      .raw_pressure(req_raw_pressure), .coeffs(coeffs_ff),
      .out_valid(temp_valid), .out_data(temp_data)
   );

   btc_press_pre u_pre (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(temp_valid), .in_data(temp_data), .coeffs(coeffs_ff),
      .out_valid(pre_valid), .out_data(pre_data)
   );

   btc_div u_div (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(pre_valid), .in_data(pre_data),
      .out_valid(div_valid), .out_data(div_data)
   );

   btc_press_post u_post (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(div_valid), .in_data(div_data), .coeffs(coeffs_ff),
      .out_valid(rsp_valid), .temperature_centi(centi_w),
      .pressure_q24_8(rsp_pressure_q24_8), .pressure_invalid(rsp_pressure_invalid)
   );

   assign rsp_temperature_centi = $signed(centi_w);

endmodule
